// File: sv/eat_pkg.sv
// eat_pkg: shared types, register codes and helper functions for the
// effective address translate unit; no dependencies
package eat_pkg;

  // number of block map register pairs held in the register file
  localparam int BLOCK_SLOTS = 4;

  // register indexes on the configuration port
  localparam logic [2:0] REG_BAT0  = 3'd0;
  localparam logic [2:0] REG_BAT1  = 3'd1;
  localparam logic [2:0] REG_BAT2  = 3'd2;
  localparam logic [2:0] REG_BAT3  = 3'd3;
  localparam logic [2:0] REG_TABLE = 3'd4;

  // segment bus unit id that marks a memory-forced segment
  localparam logic [8:0] BUID_MEM_FORCED = 9'h07F;

  // attribute codes for the direct and memory-forced paths
  localparam logic [2:0] WIM_DIRECT     = 3'd1;
  localparam logic [2:0] WIM_MEM_FORCED = 3'd3;

  // protection codes
  localparam logic [1:0] PP_NO_ACCESS = 2'd0;
  localparam logic [1:0] PP_READ_WRITE = 2'd2;
  localparam logic [1:0] PP_READ_ONLY = 2'd3;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_PROT   = 2'd1,
    ST_IOSEG  = 2'd2,
    ST_SEARCH = 2'd3
  } status_t;

  typedef struct packed {
    logic [31:0] effective_address;
    logic [31:0] segment_word;
    logic        user_mode;
    logic        is_store;
    logic        translation_enabled;
  } in_beat_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] physical_address;
    logic [2:0]  wimg_bits;
    logic        store_clean;
    logic [31:0] primary_group_address;
    logic [31:0] secondary_group_address;
    logic [31:0] entry_match_word;
  } out_beat_t;

  // result of checking one block map against one access
  typedef struct packed {
    logic        hit;
    logic        allowed;
    logic        clean;
    logic [31:0] pa;
    logic [2:0]  wimg;
  } bat_hit_t;

  // key and pp protection check
  function automatic logic access_allowed(input logic key, input logic [1:0] pp,
                                          input logic store);
    logic ok;
    if (!key) begin
      ok = !(store && (pp == PP_READ_ONLY));
    end else if (pp == PP_READ_WRITE) begin
      ok = 1'b1;
    end else begin
      ok = !store && (pp != PP_NO_ACCESS);
    end
    return ok;
  endfunction

  // page table entry group address from a 19 bit hash
  function automatic logic [31:0] group_address(input logic [31:0] setup,
                                                input logic [18:0] hs);
    logic [8:0] upper;
    upper = hs[18:10] & setup[8:0];
    return {setup[31:16], 16'h0000} | {7'd0, upper, 16'h0000} | {16'h0000, hs[9:0], 6'd0};
  endfunction

endpackage

// File: sv/eat_bat_match.sv
// eat_bat_match: compares one access against one block map pair and
// computes its protection and mapped address; uses eat_pkg
module eat_bat_match (
  input  logic [63:0]       bat_pair,
  input  logic [31:0]       ea,
  input  logic              user_mode,
  input  logic              is_store,
  output eat_pkg::bat_hit_t result
);

  logic [31:0] bu;
  logic [31:0] bl;
  logic [31:0] block_mask;
  logic        key;

  assign bu = bat_pair[63:32];
  assign bl = bat_pair[31:0];

  // block size mask opens bits 22:17 of the compare
  assign block_mask = {9'h1FF, ~bl[5:0], 17'd0};
  assign key        = user_mode ? bu[2] : bu[3];

  // hit, protection and translated address
  always_comb begin
    result.hit     = bl[6] && ((ea & block_mask) == (bu & block_mask));
    result.allowed = eat_pkg::access_allowed(key, bu[1:0], is_store);
    result.clean   = eat_pkg::access_allowed(key, bu[1:0], 1'b1);
    result.pa      = (bl & 32'hFFFE_0000 & block_mask) | (ea & ~block_mask);
    result.wimg    = bu[6:4];
  end

endmodule

// File: sv/eat_resolve.sv
// eat_resolve: picks the lowest matching block map, applies the segment
// and translation-off rules and builds the table search operands; uses eat_pkg
module eat_resolve #(
  parameter int NUM_MAPS = 4
) (
  input  eat_pkg::in_beat_t beat,
  input  eat_pkg::bat_hit_t bat_res [NUM_MAPS],
  input  logic [31:0]       table_setup,
  output eat_pkg::out_beat_t res
);

  logic [31:0] ea;
  logic [31:0] sr;
  logic [23:0] vsid;
  logic [18:0] hash;

  assign ea   = beat.effective_address;
  assign sr   = beat.segment_word;
  assign vsid = sr[23:0];
  assign hash = vsid[18:0] ^ {3'd0, ea[27:12]};

  always_comb begin
    logic              any_hit;
    eat_pkg::bat_hit_t sel;
    any_hit = 1'b0;
    sel     = bat_res[0];
    res     = '0;
    res.status = eat_pkg::ST_OK;

    // lowest index wins, so scan from the top down
    for (int i = NUM_MAPS - 1; i >= 0; i--) begin
      if (bat_res[i].hit) begin
        any_hit = 1'b1;
        sel     = bat_res[i];
      end
    end

    if (sr[31]) begin
      // direct-store segment: memory-forced or io
      if (sr[28:20] == eat_pkg::BUID_MEM_FORCED) begin
        res.physical_address = {sr[3:0], ea[27:0]};
        res.wimg_bits        = eat_pkg::WIM_MEM_FORCED;
        res.store_clean      = 1'b1;
      end else begin
        res.status = eat_pkg::ST_IOSEG;
      end
    end else if (!beat.translation_enabled) begin
      res.physical_address = ea;
      res.wimg_bits        = eat_pkg::WIM_DIRECT;
      res.store_clean      = 1'b1;
    end else if (any_hit) begin
      if (!sel.allowed) begin
        res.status = eat_pkg::ST_PROT;
      end else begin
        res.physical_address = sel.pa;
        res.wimg_bits        = sel.wimg;
        res.store_clean      = sel.clean;
      end
    end else begin
      // block maps missed: hand back the hashed table search operands
      res.status                  = eat_pkg::ST_SEARCH;
      res.primary_group_address   = eat_pkg::group_address(table_setup, hash);
      res.secondary_group_address = eat_pkg::group_address(table_setup, ~hash);
      res.entry_match_word        = {1'b1, vsid, 1'b0, ea[27:22]};
    end
  end

endmodule

// File: sv/effective_address_translate_unit.sv
// effective_address_translate_unit: top level, register file and the
// three stage translate pipeline; uses eat_pkg, eat_bat_match, eat_resolve
//
//   channel  ports                              beat
//   input    in_valid, in_stall, in_data        one access (eat_pkg::in_beat_t)
//   result   out_valid, out_stall, out_data     one result (eat_pkg::out_beat_t)
//   config   psel, penable, pwrite, paddr,      64 bit registers at 8*index
//            pwdata, prdata, pready
//
// One access enters per cycle while in_stall is low; its result passes the stages in turn.
// Depth is set by the input register, the block map compare register and
// the output register. Reset clears the valid bits and the configuration
// registers to zero.
// A stall at the output holds the full stages and fills any empty ones;
// in_stall rises only when every stage holds a beat that cannot move.
module effective_address_translate_unit #(
  parameter int NUM_BLOCK_MAPS = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  eat_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output eat_pkg::out_beat_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [5:0]         paddr,
  input  logic [63:0]        pwdata,
  output logic [63:0]        prdata,
  output logic               pready
);

  logic [63:0] bat_pair_r [eat_pkg::BLOCK_SLOTS];
  logic [31:0] table_setup_r;
  logic [2:0]  reg_idx;
  logic        cfg_write;

  logic                s1_valid_r;
  eat_pkg::in_beat_t   s1_beat_r;
  logic                s2_valid_r;
  eat_pkg::in_beat_t   s2_beat_r;
  eat_pkg::bat_hit_t   s2_bat_r [NUM_BLOCK_MAPS];
  eat_pkg::bat_hit_t   bat_nxt  [NUM_BLOCK_MAPS];
  logic                out_valid_r;
  eat_pkg::out_beat_t  out_beat_r;
  eat_pkg::out_beat_t  res_nxt;

  logic en_out;
  logic en_s2;
  logic en_s1;

  // register file access
  assign pready    = 1'b1;
  assign reg_idx   = paddr[5:3];
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    case (reg_idx)
      eat_pkg::REG_BAT0:  prdata = bat_pair_r[0];
      eat_pkg::REG_BAT1:  prdata = bat_pair_r[1];
      eat_pkg::REG_BAT2:  prdata = bat_pair_r[2];
      eat_pkg::REG_BAT3:  prdata = bat_pair_r[3];
      eat_pkg::REG_TABLE: prdata = {32'd0, table_setup_r};
      default:            prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < eat_pkg::BLOCK_SLOTS; i++) begin
        bat_pair_r[i] <= '0;
      end
      table_setup_r <= '0;
    end else if (cfg_write) begin
      case (reg_idx)
        eat_pkg::REG_BAT0:  bat_pair_r[0] <= pwdata;
        eat_pkg::REG_BAT1:  bat_pair_r[1] <= pwdata;
        eat_pkg::REG_BAT2:  bat_pair_r[2] <= pwdata;
        eat_pkg::REG_BAT3:  bat_pair_r[3] <= pwdata;
        eat_pkg::REG_TABLE: table_setup_r <= pwdata[31:0];
        default:            ;
      endcase
    end
  end

  // stage advance: a stage moves when it is empty or the next one moves
  assign en_out   = !out_valid_r || !out_stall;
  assign en_s2    = !s2_valid_r || en_out;
  assign en_s1    = !s1_valid_r || en_s2;
  assign in_stall = !en_s1;

  // block map compare, one unit per map
  for (genvar g = 0; g < NUM_BLOCK_MAPS; g++) begin : g_bat
    eat_bat_match u_match (
      .bat_pair  (bat_pair_r[g]),
      .ea        (s1_beat_r.effective_address),
      .user_mode (s1_beat_r.user_mode),
      .is_store  (s1_beat_r.is_store),
      .result    (bat_nxt[g])
    );
  end

  // final selection
  eat_resolve #(
    .NUM_MAPS (NUM_BLOCK_MAPS)
  ) u_resolve (
    .beat        (s2_beat_r),
    .bat_res     (s2_bat_r),
    .table_setup (table_setup_r),
    .res         (res_nxt)
  );

  // pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en_s1) s1_valid_r <= in_valid;
      if (en_s2) s2_valid_r <= s1_valid_r;
      if (en_out) out_valid_r <= s2_valid_r;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (en_s1) begin
      s1_beat_r <= in_data;
    end
    if (en_s2) begin
      s2_beat_r <= s1_beat_r;
      for (int i = 0; i < NUM_BLOCK_MAPS; i++) begin
        s2_bat_r[i] <= bat_nxt[i];
      end
    end
    if (en_out) begin
      out_beat_r <= res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_beat_r;

endmodule
